>>> sv/abm_pkg.sv
`default_nettype none

package abm_pkg;

    // Field widths of the request and response transfers
    localparam int OP_W   = 3;
    localparam int ID_W   = 3;
    localparam int ADDR_W = 32;
    localparam int FLAG_W = 8;
    localparam int CNT_W  = 4;

    // Request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CREATE     = 3'd0,
        OP_FREE       = 3'd1,
        OP_ENABLE     = 3'd2,
        OP_DISABLE    = 3'd3,
        OP_CHECK      = 3'd4,
        OP_IS_ENABLED = 3'd5,
        OP_NEXT_FREE  = 3'd6,
        OP_COUNT      = 3'd7
    } op_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_WRITE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
    } ctl_cmd_t;

endpackage

`default_nettype wire

>>> sv/abm_req_if.sv
`default_nettype none

interface abm_req_if import abm_pkg::*; ();
    logic                valid;
    logic                ready;
    op_t                 op;
    logic [ID_W-1:0]     entry_id;
    logic [ADDR_W-1:0]   addr;
    logic [FLAG_W-1:0]   access_flags;

    modport source (output valid, output op, output entry_id, output addr,
                    output access_flags, input ready);
    modport sink   (input valid, input op, input entry_id, input addr,
                    input access_flags, output ready);
endinterface

`default_nettype wire

>>> sv/abm_rsp_if.sv
`default_nettype none

interface abm_rsp_if import abm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                ok;
    logic [ID_W-1:0]     entry_index;
    logic                hit;
    logic                enabled;
    logic [CNT_W-1:0]    used_count;

    modport source (output valid, output ok, output entry_index, output hit,
                    output enabled, output used_count, input ready);
    modport sink   (input valid, input ok, input entry_index, input hit,
                    input enabled, input used_count, output ready);
endinterface

`default_nettype wire

>>> sv/address_breakpoint_match_table.sv
`default_nettype none

// Breakpoint/watchpoint table with address and access-flag matching. Each
// request passes from transfer to response through a latch step, a compare
// step in which every entry compares its address and flags in parallel into a
// registered match vector, and a commit step that picks the lowest hit and
// updates the table. A new request is taken only after the previous one
// commits, so one request is in flight at a time; a response left waiting in
// the output register holds the commit of the following request until it
// transfers. Writing cfg_wr_data clears the table; the user must write it only
// while no request is in flight, since the block itself does not enforce this.
module address_breakpoint_match_table
    import abm_pkg::*;
#(
    parameter int NUM_ENTRIES = 8,
    parameter int FLAG_BITS   = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [CNT_W-1:0] cfg_wr_data,
    abm_req_if.sink               req,
    abm_rsp_if.source             rsp
);

    ctl_cmd_t cmd;

    // Sequence each request through latch, compare and commit
    abm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Hold the table and compute responses
    abm_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .FLAG_BITS   (FLAG_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .op           (req.op),
        .entry_id     (req.entry_id),
        .addr         (req.addr),
        .access_flags (req.access_flags),
        .ok           (rsp.ok),
        .entry_index  (rsp.entry_index),
        .hit          (rsp.hit),
        .enabled      (rsp.enabled),
        .used_count   (rsp.used_count)
    );

endmodule

`default_nettype wire

>>> sv/abm_ctrl.sv
`default_nettype none

module abm_ctrl
    import abm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output ctl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_commit;

    // Commit only when the response register is empty or drains this cycle
    assign can_commit = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (can_commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.eval   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MATCH:
            begin
                cmd.eval = 1'b1;
            end
            ST_WRITE:
            begin
                cmd.commit = can_commit;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Set on commit, drop once the response transfer completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> sv/abm_datapath.sv
`default_nettype none

module abm_datapath
    import abm_pkg::*;
#(
    parameter int NUM_ENTRIES = 8,
    parameter int FLAG_BITS   = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctl_cmd_t          cmd,
    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data,
    input  wire op_t               op,
    input  wire logic [ID_W-1:0]   entry_id,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [FLAG_W-1:0] access_flags,
    output logic                   ok,
    output logic [ID_W-1:0]        entry_index,
    output logic                   hit,
    output logic                   enabled,
    output logic [CNT_W-1:0]       used_count
);

    // Only ids reachable through entry_id get storage; higher ones stay free
    localparam int ID_SPAN = 1 << ID_W;
    localparam int STORE   = (NUM_ENTRIES < ID_SPAN) ? NUM_ENTRIES : ID_SPAN;
    localparam int SW      = (FLAG_BITS < FLAG_W) ? FLAG_BITS : FLAG_W;
    localparam logic [6:0]       NUM_LIM   = 7'(NUM_ENTRIES);
    localparam logic [CNT_W-1:0] STORE_CNT = CNT_W'(STORE);
    localparam logic [ID_W-1:0]  STORE_IDX = ID_W'(STORE);

    // Latched request
    op_t               op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SW-1:0]     flags_reg;

    // Table state
    logic [CNT_W-1:0]  size_reg;
    logic [CNT_W-1:0]  size_next;
    logic [STORE-1:0]  alloc_reg;
    logic [STORE-1:0]  alloc_next;
    logic [STORE-1:0]  en_reg;
    logic [STORE-1:0]  en_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ADDR_W-1:0] entry_addr_reg [STORE];
    logic [SW-1:0]     entry_flags_reg [STORE];

    // Compare stage results
    logic [STORE-1:0]  match_reg;
    logic [STORE-1:0]  match_next;
    logic [STORE-1:0]  free_reg;
    logic [STORE-1:0]  free_next;

    // Commit stage
    logic [STORE-1:0]  sel;
    logic              id_ok;
    logic              alloc_sel;
    logic              en_sel;
    logic              tail_free;
    logic [ID_W-1:0]   match_idx;
    logic [ID_W-1:0]   free_idx;
    logic              res_ok;
    logic [ID_W-1:0]   res_idx;
    logic              res_hit;
    logic              res_en;
    logic              wr_entry;

    // Latch the request on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            id_reg    <= entry_id;
            addr_reg  <= addr;
            flags_reg <= access_flags[SW-1:0];
        end
    end

    // Compare every entry against the latched request
    always_comb
    begin
        for (int i = 0; i < STORE; i++)
        begin
            match_next[i] = (CNT_W'(i) < size_reg) && alloc_reg[i] && en_reg[i] &&
                            (entry_addr_reg[i] == addr_reg) &&
                            (|(entry_flags_reg[i] & flags_reg));
            free_next[i]  = (CNT_W'(i) < size_reg) && !alloc_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            match_reg <= match_next;
            free_reg  <= free_next;
        end
    end

    // Decode the id and pick the lowest matching and free entries
    always_comb
    begin
        for (int i = 0; i < STORE; i++)
        begin
            sel[i] = (id_reg == ID_W'(i));
        end
        id_ok     = {1'b0, id_reg} < size_reg;
        alloc_sel = |(alloc_reg & sel);
        en_sel    = |(en_reg & sel);
        tail_free = STORE_CNT < size_reg;
        match_idx = '0;
        free_idx  = '0;
        for (int i = STORE - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                match_idx = ID_W'(i);
            end
            if (free_reg[i])
            begin
                free_idx = ID_W'(i);
            end
        end
    end

    // Operation decode
    always_comb
    begin
        res_ok     = 1'b0;
        res_idx    = '0;
        res_hit    = 1'b0;
        res_en     = 1'b0;
        wr_entry   = 1'b0;
        alloc_next = alloc_reg;
        en_next    = en_reg;
        count_next = count_reg;
        unique case (op_reg) inside
            OP_CREATE:
            begin
                if (id_ok && !alloc_sel)
                begin
                    res_ok     = 1'b1;
                    res_idx    = id_reg;
                    wr_entry   = 1'b1;
                    alloc_next = alloc_reg | sel;
                    en_next    = en_reg | sel;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_FREE:
            begin
                if (id_ok && alloc_sel)
                begin
                    res_ok     = 1'b1;
                    res_idx    = id_reg;
                    alloc_next = alloc_reg & ~sel;
                    en_next    = en_reg & ~sel;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            OP_ENABLE, OP_DISABLE:
            begin
                if (id_ok && alloc_sel)
                begin
                    res_ok  = 1'b1;
                    res_idx = id_reg;
                    en_next = (op_reg == OP_ENABLE) ? (en_reg | sel) : (en_reg & ~sel);
                end
            end
            OP_CHECK:
            begin
                res_ok  = 1'b1;
                res_hit = |match_reg;
                res_idx = match_idx;
            end
            OP_IS_ENABLED:
            begin
                if (id_ok)
                begin
                    res_ok  = 1'b1;
                    res_idx = id_reg;
                    res_en  = en_sel;
                end
            end
            OP_NEXT_FREE:
            begin
                // Entries above the stored range are never allocated
                if (|free_reg)
                begin
                    res_ok  = 1'b1;
                    res_idx = free_idx;
                end
                else if (tail_free)
                begin
                    res_ok  = 1'b1;
                    res_idx = STORE_IDX;
                end
            end
            OP_COUNT:
            begin
                res_ok = 1'b1;
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
    end

    // Saturate the size register to the table depth
    assign size_next = ({3'b000, cfg_wr_data} > NUM_LIM) ? NUM_LIM[CNT_W-1:0] : cfg_wr_data;

    // Table control state; a size write clears the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= '0;
            alloc_reg <= '0;
            en_reg    <= '0;
            count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            size_reg  <= size_next;
            alloc_reg <= '0;
            en_reg    <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            alloc_reg <= alloc_next;
            en_reg    <= en_next;
            count_reg <= count_next;
        end
    end

    // Entry payload, written on a successful create
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE; i++)
        begin
            if (cmd.commit && wr_entry && sel[i])
            begin
                entry_addr_reg[i]  <= addr_reg;
                entry_flags_reg[i] <= flags_reg;
            end
        end
    end

    // Response register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            ok          <= res_ok;
            entry_index <= res_idx;
            hit         <= res_hit;
            enabled     <= res_en;
            used_count  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import abm_pkg::*;

    localparam int TABLE_DEPTH   = 8;
    localparam int STALL_LIMIT   = 500;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        op_t               op;
        logic [ID_W-1:0]   entry_id;
        logic [ADDR_W-1:0] addr;
        logic [FLAG_W-1:0] access_flags;
    } bp_request_t;

    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   entry_index;
        logic              hit;
        logic              enabled;
        logic [CNT_W-1:0]  used_count;
    } bp_response_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;

    abm_req_if req_bus ();
    abm_rsp_if rsp_bus ();

    address_breakpoint_match_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_bus),
        .rsp         (rsp_bus)
    );

    // Shadow copy of the breakpoint table
    logic [ADDR_W-1:0] bp_addr  [TABLE_DEPTH];
    logic [FLAG_W-1:0] bp_flags [TABLE_DEPTH];
    logic              bp_alloc [TABLE_DEPTH];
    logic              bp_en    [TABLE_DEPTH];
    logic [CNT_W-1:0]  bp_count;
    int                bp_size;

    bp_request_t  request_queue[$];
    bp_response_t predicted_responses[$];
    logic [ADDR_W-1:0] addr_pool[4];

    bit idle_on;
    bit req_fired;
    bit rsp_fired;
    int req_gap;
    int rsp_stall;
    int quiet_cycles;
    int queued_total;
    int checked_total;
    int mismatch_count;
    int check_hits;
    int sizes_run;

    // Clear every entry of the shadow table
    function automatic void clear_shadow_table();
        int i;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            bp_addr[i]  = '0;
            bp_flags[i] = '0;
            bp_alloc[i] = 1'b0;
            bp_en[i]    = 1'b0;
        end
        bp_count = '0;
    endfunction

    // Apply one request to the shadow table and return the response it yields
    function automatic bp_response_t breakpoint_table_step(bp_request_t r);
        bp_response_t res;
        bit           id_ok;
        int           i;
        res   = '0;
        id_ok = (int'(r.entry_id) < bp_size);
        case (r.op)
            OP_CREATE:
            begin
                if (id_ok && !bp_alloc[r.entry_id])
                begin
                    bp_alloc[r.entry_id] = 1'b1;
                    bp_en[r.entry_id]    = 1'b1;
                    bp_addr[r.entry_id]  = r.addr;
                    bp_flags[r.entry_id] = r.access_flags;
                    bp_count             = bp_count + 1'b1;
                    res.ok               = 1'b1;
                    res.entry_index      = r.entry_id;
                end
            end
            OP_FREE:
            begin
                if (id_ok && bp_alloc[r.entry_id])
                begin
                    bp_alloc[r.entry_id] = 1'b0;
                    bp_en[r.entry_id]    = 1'b0;
                    if (bp_count != 0)
                        bp_count = bp_count - 1'b1;
                    res.ok          = 1'b1;
                    res.entry_index = r.entry_id;
                end
            end
            OP_ENABLE, OP_DISABLE:
            begin
                if (id_ok && bp_alloc[r.entry_id])
                begin
                    bp_en[r.entry_id] = (r.op == OP_ENABLE);
                    res.ok            = 1'b1;
                    res.entry_index   = r.entry_id;
                end
            end
            OP_CHECK:
            begin
                res.ok = 1'b1;
                for (i = 0; i < bp_size; i++)
                begin
                    if (!res.hit && bp_alloc[i] && bp_en[i] && bp_addr[i] == r.addr &&
                        (bp_flags[i] & r.access_flags) != '0)
                    begin
                        res.hit         = 1'b1;
                        res.entry_index = ID_W'(i);
                    end
                end
            end
            OP_IS_ENABLED:
            begin
                if (id_ok)
                begin
                    res.ok          = 1'b1;
                    res.entry_index = r.entry_id;
                    res.enabled     = bp_en[r.entry_id];
                end
            end
            OP_NEXT_FREE:
            begin
                for (i = 0; i < bp_size; i++)
                begin
                    if (!res.ok && !bp_alloc[i])
                    begin
                        res.ok          = 1'b1;
                        res.entry_index = ID_W'(i);
                    end
                end
            end
            default:
                res.ok = 1'b1;
        endcase
        res.used_count = bp_count;
        return res;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Track transfers, predict on each request, check each response
    always @(posedge clk)
    begin
        bp_request_t  got_req;
        bp_response_t got_rsp;
        bp_response_t want;
        req_fired = rst_n && req_bus.valid && req_bus.ready;
        rsp_fired = rst_n && rsp_bus.valid && rsp_bus.ready;
        if (req_fired)
        begin
            got_req = '{req_bus.op, req_bus.entry_id, req_bus.addr, req_bus.access_flags};
            predicted_responses.push_back(breakpoint_table_step(got_req));
        end
        if (rsp_fired)
        begin
            got_rsp = '{rsp_bus.ok, rsp_bus.entry_index, rsp_bus.hit, rsp_bus.enabled,
                        rsp_bus.used_count};
            checked_total++;
            if (predicted_responses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] response with nothing outstanding: %p", $realtime, got_rsp);
            end
            else
            begin
                want = predicted_responses.pop_front();
                if (want.hit)
                    check_hits++;
                if (got_rsp.ok !== want.ok || got_rsp.entry_index !== want.entry_index ||
                    got_rsp.hit !== want.hit || got_rsp.enabled !== want.enabled ||
                    got_rsp.used_count !== want.used_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] response mismatch: expected %p, got %p",
                                 $realtime, want, got_rsp);
                end
            end
        end
        // Watchdog on cycles with no transfer
        if (!rst_n || req_fired || rsp_fired)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Drive requests from the queue and random ready stalls on the response side
    always @(negedge clk)
    begin
        bp_request_t nxt;
        if (rst_n)
        begin
            if (!req_bus.valid || req_fired)
            begin
                if (req_gap > 0)
                begin
                    req_bus.valid <= 1'b0;
                    req_gap--;
                end
                else if (request_queue.size() != 0)
                begin
                    nxt = request_queue.pop_front();
                    req_bus.valid        <= 1'b1;
                    req_bus.op           <= nxt.op;
                    req_bus.entry_id     <= nxt.entry_id;
                    req_bus.addr         <= nxt.addr;
                    req_bus.access_flags <= nxt.access_flags;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        req_gap = $urandom_range(1, 18);
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
            if (rsp_stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                rsp_stall--;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    rsp_stall = $urandom_range(1, 18);
            end
        end
    end

    task automatic queue_request(op_t op, int id, logic [ADDR_W-1:0] addr,
                                 logic [FLAG_W-1:0] flags);
        request_queue.push_back('{op, ID_W'(id), addr, flags});
        queued_total++;
    endtask

    // Hold until every queued request has its response, then let the pipe settle
    task automatic wait_for_drain();
        while (checked_total < queued_total)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_table_size(logic [CNT_W-1:0] value);
        wait_for_drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        bp_size = (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
        clear_shadow_table();
        sizes_run++;
    endtask

    // Mostly well-formed traffic on a small address pool so checks find hits
    task automatic queue_random_traffic(int count);
        int                n;
        int                roll;
        int                id;
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [FLAG_W-1:0] flags;
        for (n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
                op = OP_CREATE;
            else if (roll < 35)
                op = OP_FREE;
            else if (roll < 43)
                op = OP_ENABLE;
            else if (roll < 51)
                op = OP_DISABLE;
            else if (roll < 78)
                op = OP_CHECK;
            else if (roll < 86)
                op = OP_IS_ENABLED;
            else if (roll < 94)
                op = OP_NEXT_FREE;
            else
                op = OP_COUNT;
            if (bp_size == 0 || $urandom_range(0, 9) == 0)
                id = $urandom_range(0, 7);
            else
                id = $urandom_range(0, bp_size - 1);
            if ($urandom_range(0, 9) < 7)
                addr = addr_pool[$urandom_range(0, 3)];
            else
                addr = $urandom();
            if (op == OP_CHECK && $urandom_range(0, 2) == 0)
                flags = FLAG_W'(1) << $urandom_range(0, FLAG_W - 1);
            else
                flags = FLAG_W'($urandom_range(0, 255));
            queue_request(op, id, addr, flags);
        end
    endtask

    // Stimulus
    initial
    begin
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        req_bus.valid        = 1'b0;
        req_bus.op           = OP_CREATE;
        req_bus.entry_id     = '0;
        req_bus.addr         = '0;
        req_bus.access_flags = '0;
        rsp_bus.ready        = 1'b0;
        req_fired            = 1'b0;
        rsp_fired            = 1'b0;
        idle_on              = 1'b0;
        req_gap              = 0;
        rsp_stall            = 0;
        quiet_cycles         = 0;
        queued_total         = 0;
        checked_total        = 0;
        mismatch_count       = 0;
        check_hits           = 0;
        sizes_run            = 0;
        bp_size              = 0;
        clear_shadow_table();
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        addr_pool[2] = $urandom();
        addr_pool[3] = $urandom();

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Table size zero after reset: every id is out of range
        queue_request(OP_CREATE, 0, 32'h1000, 8'h01);
        queue_request(OP_CHECK, 0, 32'h1000, 8'hFF);
        queue_request(OP_NEXT_FREE, 0, '0, '0);
        queue_request(OP_COUNT, 0, '0, '0);

        // Full table: allocation states, flag overlap, enable and disable
        write_table_size(CNT_W'(8));
        queue_request(OP_CREATE, 0, 32'h0000_0000, 8'hFF);
        queue_request(OP_CREATE, 7, 32'hFFFF_FFFF, 8'h80);
        queue_request(OP_CREATE, 0, 32'h1234_5678, 8'h01);
        queue_request(OP_CHECK, 0, 32'h0000_0000, 8'h01);
        queue_request(OP_CHECK, 0, 32'hFFFF_FFFF, 8'h7F);
        queue_request(OP_CHECK, 0, 32'hFFFF_FFFF, 8'h80);
        queue_request(OP_DISABLE, 7, '0, '0);
        queue_request(OP_CHECK, 0, 32'hFFFF_FFFF, 8'hFF);
        queue_request(OP_IS_ENABLED, 7, '0, '0);
        queue_request(OP_ENABLE, 7, '0, '0);
        queue_request(OP_IS_ENABLED, 7, '0, '0);
        queue_request(OP_FREE, 0, '0, '0);
        queue_request(OP_FREE, 0, '0, '0);
        queue_request(OP_ENABLE, 0, '0, '0);
        queue_request(OP_DISABLE, 0, '0, '0);
        queue_request(OP_IS_ENABLED, 0, '0, '0);
        queue_request(OP_CHECK, 0, 32'h0000_0000, 8'hFF);
        queue_request(OP_NEXT_FREE, 0, '0, '0);
        queue_request(OP_CREATE, 3, 32'hFFFF_FFFF, 8'h00);
        queue_request(OP_CHECK, 0, 32'hFFFF_FFFF, 8'hFF);
        queue_request(OP_COUNT, 0, '0, '0);

        // Random traffic over a range of table sizes, saturating size included
        idle_on = 1'b1;
        queue_random_traffic(150);
        write_table_size(CNT_W'(15));
        queue_random_traffic(150);
        write_table_size(CNT_W'(5));
        queue_random_traffic(100);
        write_table_size(CNT_W'(1));
        queue_random_traffic(60);
        write_table_size(CNT_W'(0));
        queue_random_traffic(20);
        write_table_size(CNT_W'($urandom_range(2, 7)));
        queue_random_traffic(80);

        // Closing stretch at full rate on both sides
        write_table_size(CNT_W'(8));
        idle_on   = 1'b0;
        req_gap   = 0;
        rsp_stall = 0;
        queue_random_traffic(140);
        wait_for_drain();
        repeat (8) @(negedge clk);

        $display("covered %0d requests across %0d table sizes, %0d responses checked",
                 queued_total, sizes_run + 1, checked_total);
        $display("breakpoint checks that hit: %0d, mismatches seen: %0d",
                 check_hits, mismatch_count);
        if (mismatch_count == 0 && predicted_responses.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
